// ===== src/pgc_pkg.sv =====
// shared types and constants of the pan gain calculator
package pgc_pkg;

  localparam int POS_W  = 16;
  localparam int GAIN_W = 16;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  typedef struct packed {
    logic valid;
    logic beyond;
    logic mute;
  } ctl_t;

endpackage

// ===== src/pgc_front.sv =====
// front stages: magnitude, squares, distance term and dividends of both lanes
module pgc_front #(
  parameter int POS_FRAC_BITS  = 12,
  parameter int GAIN_FRAC_BITS = 15,
  parameter int DD_W           = 31,
  parameter int N_W            = 58
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       in_valid_i,
  input  logic [pgc_pkg::POS_W-1:0]  pos_i,
  output logic [DD_W-1:0]            dd_o,
  output logic [N_W-1:0]             num_l_o,
  output logic [N_W-1:0]             num_r_o,
  output pgc_pkg::ctl_t              ctl_l_o,
  output pgc_pkg::ctl_t              ctl_r_o
);
  import pgc_pkg::*;

  localparam int SW      = ((POS_FRAC_BITS + 2 > POS_W + 1) ? POS_FRAC_BITS + 2 : POS_W + 1) + 1;
  localparam int NUM_W   = POS_FRAC_BITS + 2;
  localparam int MSQ_W   = 2 * POS_W;
  localparam int NSQ_W   = 2 * NUM_W;
  localparam int N_SHIFT = 2 * GAIN_FRAC_BITS + 1;
  localparam logic [SW-1:0]   ONE_POS = SW'(1) << POS_FRAC_BITS;
  localparam logic [DD_W-1:0] ONE_SQ  = DD_W'(1) << (2 * POS_FRAC_BITS);
  localparam logic [N_W-1:0]  N_OUT   = N_W'(1) << (2 * POS_FRAC_BITS + GAIN_FRAC_BITS + 2);

  logic                    a_valid_q;
  logic signed [POS_W-1:0] a_pos_q;

  logic                    b_valid_q;
  logic                    b_beyond_q, b_beyond_d;
  logic                    b_neg_q;
  logic [POS_W-1:0]        b_mag_q, b_mag_d;
  logic [NUM_W-1:0]        b_num_l_q, b_num_l_d;
  logic [NUM_W-1:0]        b_num_r_q, b_num_r_d;

  logic                    c_valid_q;
  logic                    c_beyond_q;
  logic                    c_neg_q;
  logic [MSQ_W-1:0]        c_msq_q, c_msq_d;
  logic [NSQ_W-1:0]        c_nsq_l_q, c_nsq_l_d;
  logic [NSQ_W-1:0]        c_nsq_r_q, c_nsq_r_d;

  logic [DD_W-1:0]         dd_q, dd_d;
  logic [N_W-1:0]          num_l_q, num_l_d;
  logic [N_W-1:0]          num_r_q, num_r_d;
  ctl_t                    ctl_l_q, ctl_l_d;
  ctl_t                    ctl_r_q, ctl_r_d;

  logic signed [SW-1:0]    pos_ext;
  logic signed [SW-1:0]    num_l_full;
  logic signed [SW-1:0]    num_r_full;
  logic signed [SW-1:0]    mag_full;

  always_comb begin
    pos_ext    = SW'(a_pos_q);
    num_l_full = $signed(ONE_POS) - pos_ext;
    num_r_full = $signed(ONE_POS) + pos_ext;
    mag_full   = a_pos_q[POS_W-1] ? -pos_ext : pos_ext;
    b_mag_d    = mag_full[POS_W-1:0];
    b_beyond_d = mag_full > $signed(ONE_POS);
    b_num_l_d  = num_l_full[NUM_W-1:0];
    b_num_r_d  = num_r_full[NUM_W-1:0];
  end

  always_comb begin
    c_msq_d   = MSQ_W'(b_mag_q) * MSQ_W'(b_mag_q);
    c_nsq_l_d = NSQ_W'(b_num_l_q) * NSQ_W'(b_num_l_q);
    c_nsq_r_d = NSQ_W'(b_num_r_q) * NSQ_W'(b_num_r_q);
  end

  // beyond the speakers the near lane divides the fixed inverse-square dividend, the far lane a zero one
  always_comb begin
    dd_d = DD_W'(c_msq_q) + ONE_SQ;
    if (c_beyond_q) begin
      num_l_d = c_neg_q ? N_OUT : '0;
      num_r_d = c_neg_q ? '0 : N_OUT;
    end else begin
      num_l_d = N_W'(c_nsq_l_q) << N_SHIFT;
      num_r_d = N_W'(c_nsq_r_q) << N_SHIFT;
    end
    ctl_l_d = '{valid: c_valid_q, beyond: c_beyond_q, mute: c_beyond_q && !c_neg_q};
    ctl_r_d = '{valid: c_valid_q, beyond: c_beyond_q, mute: c_beyond_q && c_neg_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      ctl_l_q   <= '0;
      ctl_r_q   <= '0;
    end else if (en_i) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      ctl_l_q   <= ctl_l_d;
      ctl_r_q   <= ctl_r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_pos_q    <= pos_i;
      b_beyond_q <= b_beyond_d;
      b_neg_q    <= a_pos_q[POS_W-1];
      b_mag_q    <= b_mag_d;
      b_num_l_q  <= b_num_l_d;
      b_num_r_q  <= b_num_r_d;
      c_beyond_q <= b_beyond_q;
      c_neg_q    <= b_neg_q;
      c_msq_q    <= c_msq_d;
      c_nsq_l_q  <= c_nsq_l_d;
      c_nsq_r_q  <= c_nsq_r_d;
      dd_q       <= dd_d;
      num_l_q    <= num_l_d;
      num_r_q    <= num_r_d;
    end
  end

  assign dd_o    = dd_q;
  assign num_l_o = num_l_q;
  assign num_r_o = num_r_q;
  assign ctl_l_o = ctl_l_q;
  assign ctl_r_o = ctl_r_q;

endmodule

// ===== src/pgc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module pgc_div #(
  parameter int DD_W = 31,
  parameter int N_W  = 58,
  parameter int Q_W  = 33
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [DD_W-1:0] dd_i,
  input  logic [N_W-1:0]  num_i,
  input  pgc_pkg::ctl_t   ctl_i,
  output logic [Q_W-1:0]  quo_o,
  output pgc_pkg::ctl_t   ctl_o
);
  import pgc_pkg::*;

  localparam int R_W = DD_W + 1;

  logic [R_W-1:0]  rem_q  [Q_W];
  logic [R_W-1:0]  rem_d  [Q_W];
  logic [Q_W-1:0]  quo_q  [Q_W];
  logic [Q_W-1:0]  quo_d  [Q_W];
  logic [DD_W-1:0] dd_q   [Q_W];
  logic [DD_W-1:0] src_dd [Q_W];
  ctl_t            ctl_q  [Q_W];
  ctl_t            src_ctl[Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [R_W-1:0] src_rem;
    logic [R_W-1:0] rem_sh;
    logic [Q_W-1:0] src_quo;
    logic           take;

    if (k == 0) begin : g_first
      assign src_rem    = R_W'(num_i[N_W-1:Q_W]);
      assign src_quo    = num_i[Q_W-1:0];
      assign src_dd[k]  = dd_i;
      assign src_ctl[k] = ctl_i;
    end else begin : g_next
      assign src_rem    = rem_q[k-1];
      assign src_quo    = quo_q[k-1];
      assign src_dd[k]  = dd_q[k-1];
      assign src_ctl[k] = ctl_q[k-1];
    end

    assign rem_sh   = {src_rem[R_W-2:0], src_quo[Q_W-1]};
    assign take     = rem_sh >= R_W'(src_dd[k]);
    assign rem_d[k] = take ? rem_sh - R_W'(src_dd[k]) : rem_sh;
    assign quo_d[k] = {src_quo[Q_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Q_W; k++) ctl_q[k] <= '0;
    end else if (en_i) begin
      for (int k = 0; k < Q_W; k++) ctl_q[k] <= src_ctl[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Q_W; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        dd_q[k]  <= src_dd[k];
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];
  assign ctl_o = ctl_q[Q_W-1];

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[Q_W-1].valid |-> rem_q[Q_W-1] < R_W'(dd_q[Q_W-1]))
    else $error("divider remainder not below divisor");

endmodule

// ===== src/pgc_sqrt.sv =====
// pipelined integer square root, one root bit per stage, then round and saturate
module pgc_sqrt #(
  parameter int Q_W  = 33,
  parameter int RT_W = 17
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [Q_W-1:0]             quo_i,
  input  pgc_pkg::ctl_t              ctl_i,
  output logic [pgc_pkg::GAIN_W-1:0] gain_o,
  output pgc_pkg::ctl_t              ctl_o
);
  import pgc_pkg::*;

  localparam int RAD_W = 2 * RT_W;
  localparam int REM_W = RT_W + 3;
  localparam int CW    = (RT_W > GAIN_W) ? RT_W : GAIN_W;

  logic [REM_W-1:0] rem_q  [RT_W];
  logic [REM_W-1:0] rem_d  [RT_W];
  logic [RT_W-1:0]  root_q [RT_W];
  logic [RT_W-1:0]  root_d [RT_W];
  logic [RAD_W-1:0] rad_q  [RT_W];
  logic [RAD_W-1:0] rad_d  [RT_W];
  logic [RT_W-1:0]  byp_q  [RT_W];
  logic [RT_W-1:0]  src_byp[RT_W];
  ctl_t             ctl_q  [RT_W];
  ctl_t             src_ctl[RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic [REM_W-1:0] src_rem;
    logic [RT_W-1:0]  src_root;
    logic [RAD_W-1:0] src_rad;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;

    if (k == 0) begin : g_first
      assign src_rem    = '0;
      assign src_root   = '0;
      assign src_rad    = RAD_W'(quo_i);
      assign src_byp[k] = quo_i[RT_W-1:0];
      assign src_ctl[k] = ctl_i;
    end else begin : g_next
      assign src_rem    = rem_q[k-1];
      assign src_root   = root_q[k-1];
      assign src_rad    = rad_q[k-1];
      assign src_byp[k] = byp_q[k-1];
      assign src_ctl[k] = ctl_q[k-1];
    end

    assign rem_sh    = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
    assign trial     = REM_W'({src_root, 2'b01});
    assign take      = rem_sh >= trial;
    assign rem_d[k]  = take ? rem_sh - trial : rem_sh;
    assign root_d[k] = {src_root[RT_W-2:0], take};
    assign rad_d[k]  = src_rad << 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RT_W; k++) ctl_q[k] <= '0;
    end else if (en_i) begin
      for (int k = 0; k < RT_W; k++) ctl_q[k] <= src_ctl[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < RT_W; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
        byp_q[k]  <= src_byp[k];
      end
    end
  end

  // inside the speakers the root is rounded, beyond them the quotient is rounded in its place
  logic [RT_W-1:0] val;
  logic [RT_W:0]   rnd;
  logic [RT_W-1:0] gain;

  always_comb begin
    val = ctl_q[RT_W-1].beyond ? byp_q[RT_W-1] : root_q[RT_W-1];
    rnd = (RT_W + 1)'(val) + (RT_W + 1)'(1);
    gain = rnd[RT_W:1];
    if (ctl_q[RT_W-1].mute) begin
      gain_o = '0;
    end else if (CW'(gain) > CW'(GAIN_MAX)) begin
      gain_o = GAIN_MAX;
    end else begin
      gain_o = GAIN_W'(gain);
    end
  end

  assign ctl_o = ctl_q[RT_W-1];

  a_root_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q[RT_W-1].valid && !ctl_q[RT_W-1].beyond
      |-> rem_q[RT_W-1] <= (REM_W'(root_q[RT_W-1]) << 1))
    else $error("square root remainder out of range");

endmodule

// ===== src/pan_gain_calculator.sv =====
// top level of the pan gain calculator
// Takes one Q3.12 pan position per transaction and returns left and right gains in
// unsigned Q1.15 plus a flag that marks positions beyond the speakers. One position
// enters per clock while the output is not held; each passes the front stages, the
// restoring divider, which resolves one quotient bit per stage, the square root that
// follows it, one root bit per stage, and the output register. Both gains
// run in parallel lanes. When the output transaction is held, the whole pipeline
// holds with it and no input is taken until the output register drains.
module pan_gain_calculator #(
  parameter int GAIN_FRAC_BITS = 15,
  parameter int POS_FRAC_BITS  = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [pgc_pkg::POS_W-1:0]       s_tdata_i,   // [15:0] position
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [2*pgc_pkg::GAIN_W-1:0]    m_tdata_o,   // [15:0] left_gain, [31:16] right_gain
  output logic                            m_tuser_o    // [0] beyond_speakers
);
  import pgc_pkg::*;

  localparam int DD_W = ((2 * POS_FRAC_BITS > 30) ? 2 * POS_FRAC_BITS : 30) + 1;
  localparam int Q_W  = 2 * GAIN_FRAC_BITS + 3;
  localparam int N_W  = 2 * POS_FRAC_BITS + 2 * GAIN_FRAC_BITS + 4;
  localparam int RT_W = GAIN_FRAC_BITS + 2;

  logic                  en;
  logic [DD_W-1:0]       dd;
  logic [N_W-1:0]        num_l, num_r;
  ctl_t                  fctl_l, fctl_r;
  logic [Q_W-1:0]        quo_l, quo_r;
  ctl_t                  dctl_l, dctl_r;
  logic [GAIN_W-1:0]     gain_l, gain_r;
  ctl_t                  sctl_l, sctl_r;

  logic                  out_valid_q;
  logic [2*GAIN_W-1:0]   out_data_q;
  logic                  out_user_q;

  assign en         = !out_valid_q || m_tready_i;
  assign s_tready_o = en;

  pgc_front #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .DD_W          (DD_W),
    .N_W           (N_W)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_valid_i(s_tvalid_i),
    .pos_i     (s_tdata_i),
    .dd_o      (dd),
    .num_l_o   (num_l),
    .num_r_o   (num_r),
    .ctl_l_o   (fctl_l),
    .ctl_r_o   (fctl_r)
  );

  pgc_div #(.DD_W(DD_W), .N_W(N_W), .Q_W(Q_W)) u_div_l (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .dd_i  (dd),
    .num_i (num_l),
    .ctl_i (fctl_l),
    .quo_o (quo_l),
    .ctl_o (dctl_l)
  );

  pgc_div #(.DD_W(DD_W), .N_W(N_W), .Q_W(Q_W)) u_div_r (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .dd_i  (dd),
    .num_i (num_r),
    .ctl_i (fctl_r),
    .quo_o (quo_r),
    .ctl_o (dctl_r)
  );

  pgc_sqrt #(.Q_W(Q_W), .RT_W(RT_W)) u_sqrt_l (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .quo_i (quo_l),
    .ctl_i (dctl_l),
    .gain_o(gain_l),
    .ctl_o (sctl_l)
  );

  pgc_sqrt #(.Q_W(Q_W), .RT_W(RT_W)) u_sqrt_r (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .quo_i (quo_r),
    .ctl_i (dctl_r),
    .gain_o(gain_r),
    .ctl_o (sctl_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sctl_l.valid && sctl_r.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {gain_r, gain_l};
      out_user_q <= sctl_l.beyond;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

  a_far_side_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o
      |-> (m_tdata_o[GAIN_W-1:0] == '0) || (m_tdata_o[2*GAIN_W-1:GAIN_W] == '0))
    else $error("both gains nonzero beyond the speakers");

  a_inside_not_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o
      |-> (m_tdata_o[GAIN_W-1:0] != '0) || (m_tdata_o[2*GAIN_W-1:GAIN_W] != '0))
    else $error("both gains zero between the speakers");

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_o |-> s_tready_o)
    else $error("input blocked with empty output register");

endmodule
